>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL, included by bit_pattern_finder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// Checks that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/bpf_pkg.sv
// ---------------------------------------------------------------------------
// bpf_pkg
// Types and constants shared by the bit pattern finder modules.
// ---------------------------------------------------------------------------
package bpf_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

  // Width of the length register as written.
  localparam int LENGTH_FIELD_W = 7;

  // Width of the reported position fields.
  localparam int OUT_W = 32;

  // One stream bit with its stream-start flag.
  typedef struct packed {
    logic data_bit;
    logic first_bit;
  } bpf_item_t;

  // One match report.
  typedef struct packed {
    logic [OUT_W-1:0] match_start;
    logic [OUT_W-1:0] match_end;
    logic [OUT_W-1:0] start_delta;
  } bpf_result_t;

endpackage

>>> sv/bpf_cfg_regs.sv
// ---------------------------------------------------------------------------
// bpf_cfg_regs
// Pattern and pattern length registers behind the plain write port.
// ---------------------------------------------------------------------------
module bpf_cfg_regs import bpf_pkg::*; #(
  parameter int MAX_PATTERN_BITS = 64,
  localparam int LEN_W = $clog2(MAX_PATTERN_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic [MAX_PATTERN_BITS-1:0] pattern,
  output logic [LEN_W-1:0]            pattern_len
);

  localparam logic [LENGTH_FIELD_W-1:0] MAX_LEN_FIELD = LENGTH_FIELD_W'(MAX_PATTERN_BITS);

  logic [LENGTH_FIELD_W-1:0] len_field;
  logic [LEN_W-1:0]          len_clamped;

  // Lengths beyond the pattern store are taken as the full store.
  assign len_field   = cfg_data[LENGTH_FIELD_W-1:0];
  assign len_clamped = (len_field > MAX_LEN_FIELD) ? LEN_W'(MAX_PATTERN_BITS)
                                                    : LEN_W'(len_field);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      pattern_len <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_BITS:   pattern     <= cfg_data[MAX_PATTERN_BITS-1:0];
        REG_PATTERN_LENGTH: pattern_len <= len_clamped;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/bpf_matcher.sv
// ---------------------------------------------------------------------------
// bpf_matcher
// Stream history, position counters and the masked window compare.
// ---------------------------------------------------------------------------
module bpf_matcher import bpf_pkg::*; #(
  parameter int MAX_PATTERN_BITS = 64,
  parameter int POSITION_WIDTH   = 32,
  localparam int LEN_W = $clog2(MAX_PATTERN_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  bpf_item_t                   item,
  input  logic [MAX_PATTERN_BITS-1:0] pattern,
  input  logic [LEN_W-1:0]            pattern_len,
  output logic                        hit,
  output bpf_result_t                 result
);

  localparam int PW    = POSITION_WIDTH;
  localparam int EXT_W = POSITION_WIDTH + OUT_W;

  // Stream state; the newest bit sits at the top of the history.
  logic [MAX_PATTERN_BITS-1:0] hist;
  logic [PW-1:0]               bit_position;
  logic [PW-1:0]               earliest_start;
  logic [PW-1:0]               previous_start;

  logic [MAX_PATTERN_BITS-1:0] hist_base;
  logic [MAX_PATTERN_BITS:0]   hist_cat;
  logic [MAX_PATTERN_BITS-1:0] hist_next;
  logic [PW-1:0]               pos_cur;
  logic [PW-1:0]               earliest_cur;
  logic [PW-1:0]               previous_cur;
  logic [LEN_W-1:0]            shift_amt;
  logic [MAX_PATTERN_BITS-1:0] window;
  logic [MAX_PATTERN_BITS-1:0] mask;
  logic                        bits_equal;
  logic                        pos_sat;
  logic [PW:0]                 pos_plus1;
  logic [PW:0]                 len_ext;
  logic                        too_short;
  logic [PW:0]                 start_wide;
  logic [PW-1:0]               start;
  logic [PW-1:0]               delta;
  logic [EXT_W-1:0]            start_ext;
  logic [EXT_W-1:0]            end_ext;
  logic [EXT_W-1:0]            delta_ext;

  // A first bit restarts the stream from an empty history.
  assign hist_base    = item.first_bit ? '0 : hist;
  assign pos_cur      = item.first_bit ? '0 : bit_position;
  assign earliest_cur = item.first_bit ? '0 : earliest_start;
  assign previous_cur = item.first_bit ? '0 : previous_start;
  assign hist_cat     = {item.data_bit, hist_base};
  assign hist_next    = hist_cat[MAX_PATTERN_BITS:1];

  // Align the newest pattern_len bits to the bottom and compare under a mask.
  assign shift_amt = LEN_W'(MAX_PATTERN_BITS) - pattern_len;
  assign window    = hist_next >> shift_amt;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BITS; i++) begin
      mask[i] = (LEN_W'(i) < pattern_len);
    end
  end

  assign bits_equal = (((window ^ pattern) & mask) == '0);

  // Position checks: saturated count, stream too short, overlap with last match.
  assign pos_sat    = (pos_cur == {PW{1'b1}});
  assign pos_plus1  = {1'b0, pos_cur} + (PW+1)'(1);
  assign len_ext    = (PW+1)'(pattern_len);
  assign too_short  = (pos_plus1 < len_ext);
  assign start_wide = pos_plus1 - len_ext;
  assign start      = start_wide[PW-1:0];
  assign delta      = start - previous_cur;

  assign hit = (pattern_len != '0) && !pos_sat && !too_short &&
               (start >= earliest_cur) && bits_equal;

  // Report positions in the low bits of the output fields.
  assign start_ext          = EXT_W'(start);
  assign end_ext            = EXT_W'(pos_cur);
  assign delta_ext          = EXT_W'(delta);
  assign result.match_start = start_ext[OUT_W-1:0];
  assign result.match_end   = end_ext[OUT_W-1:0];
  assign result.start_delta = delta_ext[OUT_W-1:0];

  // State update once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist           <= '0;
      bit_position   <= '0;
      earliest_start <= '0;
      previous_start <= '0;
    end else if (advance) begin
      hist           <= hist_next;
      bit_position   <= pos_sat ? pos_cur : pos_plus1[PW-1:0];
      earliest_start <= hit ? pos_plus1[PW-1:0] : earliest_cur;
      previous_start <= hit ? start : previous_cur;
    end
  end

endmodule

>>> sv/bit_pattern_finder.sv
// ---------------------------------------------------------------------------
// bit_pattern_finder
// Non-overlapping search for a configured bit pattern in a serial stream.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_ready   data_bit, first_bit
//   output    out        out_valid / out_ready match_start, match_end, start_delta
//   config    in         cfg_write             cfg_index, cfg_data
//
// One bit per cycle is taken while the output does not stall; a bit passes
// from the input register to the result register, which holds its result (or none).
// The window compare and position checks sit in one pass between the input
// register and the result register.
// Reset clears the pattern, the length, the history and all counters.
// A stalled output holds the input register; a new bit is still taken
// whenever the held one moves on in the same cycle.
//
module bit_pattern_finder import bpf_pkg::*; #(
  parameter int MAX_PATTERN_BITS = 64,
  parameter int POSITION_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   data_bit,
  input  logic                   first_bit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       match_start,
  output logic [OUT_W-1:0]       match_end,
  output logic [OUT_W-1:0]       start_delta,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int LEN_W = $clog2(MAX_PATTERN_BITS + 1);

  logic [MAX_PATTERN_BITS-1:0] pattern;
  logic [LEN_W-1:0]            pattern_len;
  logic                        in_full;
  bpf_item_t                   in_item;
  logic                        advance;
  logic                        hit;
  bpf_result_t                 result;
  bpf_result_t                 out_result;

  bpf_cfg_regs #(
    .MAX_PATTERN_BITS(MAX_PATTERN_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pattern    (pattern),
    .pattern_len(pattern_len)
  );

  // The held item moves on when the result register is free or being emptied.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.data_bit  <= data_bit;
      in_item.first_bit <= first_bit;
    end
  end

  bpf_matcher #(
    .MAX_PATTERN_BITS(MAX_PATTERN_BITS),
    .POSITION_WIDTH  (POSITION_WIDTH)
  ) u_matcher (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (in_item),
    .pattern    (pattern),
    .pattern_len(pattern_len),
    .hit        (hit),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_result <= result;
    end
  end

  assign match_start = out_result.match_start;
  assign match_end   = out_result.match_end;
  assign start_delta = out_result.start_delta;

  // A held item with a stalled result must not take another bit.
  `ASSERT_ALWAYS(a_stall_blocks_input, clk, rst, !(in_full && out_valid && !out_ready) || !in_ready)
  // An item that moves on shows a result exactly when it matched.
  `ASSERT_NEXT(a_result_follows_hit, clk, rst, advance, out_valid == $past(hit))
  // Both registers come out of reset empty.
  `ASSERT_ALWAYS(a_empty_after_reset, clk, rst, !$past(rst) || (!out_valid && !in_full))

endmodule

>>> verif/bit_pattern_checker.sv
// ---------------------------------------------------------------------------
// bit_pattern_checker
// Watches the stream, configuration and match channels of the bit pattern
// finder, predicts every match from the accepted bits and compares each
// reported match field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module bit_pattern_checker import bpf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   data_bit,
  input  logic                   first_bit,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_W-1:0]       match_start,
  input  logic [OUT_W-1:0]       match_end,
  input  logic [OUT_W-1:0]       start_delta,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     matches_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // The position counter stops here; a bit at this position never ends a match.
  localparam logic [OUT_W-1:0] POS_LIMIT = '1;
  localparam logic [6:0]       MAX_LEN   = 7'd64;

  // Shadow copy of the registers and the search state.
  logic [63:0]      pat_reg;
  logic [6:0]       len_reg;
  logic [63:0]      history;
  logic [OUT_W-1:0] next_pos;
  logic [OUT_W-1:0] min_start;
  logic [OUT_W-1:0] last_start;

  // Matches predicted but not yet reported, oldest first.
  bpf_result_t due_matches[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    matches_seen = 0;
  end

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    logic [OUT_W-1:0] pos;
    logic [OUT_W-1:0] start;
    logic [6:0]       eff_len;
    logic [63:0]      mask;
    logic [63:0]      window;
    bpf_result_t      res;
    bpf_result_t      want;
    if (rst) begin
      pat_reg    = '0;
      len_reg    = '0;
      history    = '0;
      next_pos   = '0;
      min_start  = '0;
      last_start = '0;
      due_matches.delete();
      pending    = 0;
    end else begin
      // Compare the reported match before this edge's bit is predicted, so a
      // stray report cannot consume a prediction made in the same cycle.
      if (out_valid && out_ready) begin
        if (due_matches.size() == 0) begin
          $display("%0t: stray match, start %0d end %0d delta %0d, none expected",
                   $time, match_start, match_end, start_delta);
          fail_count++;
        end else begin
          want = due_matches.pop_front();
          check_field("match_start", want.match_start, match_start);
          check_field("match_end", want.match_end, match_end);
          check_field("start_delta", want.start_delta, start_delta);
          matches_seen++;
        end
      end

      // Register writes; unused indexes have no effect.
      if (cfg_write) begin
        if (cfg_index == REG_PATTERN_BITS) begin
          pat_reg = cfg_data;
        end else if (cfg_index == REG_PATTERN_LENGTH) begin
          len_reg = cfg_data[LENGTH_FIELD_W-1:0];
        end
      end

      // Predict the result of each stream bit transfer.
      if (in_valid && in_ready) begin
        if (first_bit) begin
          history    = '0;
          next_pos   = '0;
          min_start  = '0;
          last_start = '0;
        end
        pos     = next_pos;
        history = {data_bit, history[63:1]};
        if (next_pos != POS_LIMIT) begin
          next_pos = next_pos + 1'b1;
        end
        // Lengths beyond the pattern store are clamped to its size.
        eff_len = (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
        start   = pos + 1'b1 - {{(OUT_W-7){1'b0}}, eff_len};
        mask    = (eff_len == MAX_LEN) ? '1 : ((64'd1 << eff_len) - 64'd1);
        window  = (history >> (MAX_LEN - eff_len)) & mask;
        // A match needs a nonzero length, a countable position, enough bits in
        // the stream, no overlap with the previous match and equal bits.
        if (eff_len != '0 && pos != POS_LIMIT &&
            ({1'b0, pos} + 1'b1) >= {{(OUT_W-6){1'b0}}, eff_len} &&
            start >= min_start && window == (pat_reg & mask)) begin
          res.match_start = start;
          res.match_end   = pos;
          res.start_delta = start - last_start;
          due_matches.push_back(res);
          last_start = start;
          min_start  = pos + 1'b1;
        end
      end
      pending = due_matches.size();
    end
  end

endmodule

>>> verif/tb_bit_pattern_finder.sv
// ---------------------------------------------------------------------------
// tb_bit_pattern_finder
// Drives stream bits and register settings into the bit pattern finder and
// gives the verdict. A directed opening covers disabled matching, one-bit and
// self-overlapping patterns, stream restarts and unused register indexes;
// random phases then embed whole and broken patterns in noise under many
// settings, with random gaps on the stream and random stalls on the matches.
// ---------------------------------------------------------------------------
module tb_bit_pattern_finder import bpf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BITS    = 950;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_WAIT_LIMIT = 2000;
  localparam int RUN_LIMIT_NS   = 5_000_000;

  // Indexes with no register behind them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   data_bit;
  logic                   first_bit;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_W-1:0]       match_start;
  logic [OUT_W-1:0]       match_end;
  logic [OUT_W-1:0]       start_delta;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int matches_seen;

  // Stimulus state: the pattern in force and its clamped length.
  logic [63:0] cur_pattern;
  int          cur_len;
  int          sent;
  int          phases;
  bit          no_gaps;
  bit          no_stall;

  bit_pattern_finder DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_bit   (data_bit),
    .first_bit  (first_bit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .match_start(match_start),
    .match_end  (match_end),
    .start_delta(start_delta),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bit_pattern_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_bit    (data_bit),
    .first_bit   (first_bit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match_start (match_start),
    .match_end   (match_end),
    .start_delta (start_delta),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .matches_seen(matches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: run limit reached with %0d matches outstanding", $time, pending);
    $display("Verification failed");
    $finish;
  end

  // Match receiver: random stalls, mostly short, some long, none in burst phases.
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (no_stall) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 65);
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      end
    end
  end

  // Idle cycles before the next stream bit.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) begin
      return 0;
    end
    return (roll < 90) ? $urandom_range(1, 3) : $urandom_range(5, 20);
  endfunction

  // One stream bit transfer; entered and left at a falling edge.
  task automatic push_bit(input logic d, input logic f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_bit  <= d;
    first_bit <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Let every predicted match come out and the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Holds the write strobe high; the caller lowers it after the last write.
  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // New register setting, written only while the block is idle.
  task automatic configure(input logic [63:0] pattern, input logic [63:0] len_word,
                           input bit spare);
    int l;
    settle();
    if ($urandom_range(0, 1)) begin
      cfg_put(REG_PATTERN_BITS, pattern);
      cfg_put(REG_PATTERN_LENGTH, len_word);
    end else begin
      cfg_put(REG_PATTERN_LENGTH, len_word);
      cfg_put(REG_PATTERN_BITS, pattern);
    end
    if (spare) begin
      cfg_put(REG_SPARE_2, {$urandom, $urandom});
      cfg_put(REG_SPARE_3, {$urandom, $urandom});
    end
    cfg_write <= 1'b0;
    l = int'(len_word[LENGTH_FIELD_W-1:0]);
    cur_pattern = pattern;
    cur_len     = (l > 64) ? 64 : l;
    phases++;
  endtask

  // Sends the current pattern, whole or broken by one flipped bit or a cut.
  task automatic send_pattern(input bit broken);
    int flip;
    int cut;
    flip = -1;
    cut  = cur_len;
    if (broken) begin
      if ($urandom_range(0, 1)) begin
        flip = $urandom_range(0, cur_len - 1);
      end else begin
        cut = $urandom_range(0, cur_len - 1);
      end
    end
    for (int i = 0; i < cut; i++) begin
      push_bit(cur_pattern[i] ^ (i == flip), (i == 0) && ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    int          goal;
    int          phase_end;
    int          roll;
    int          k;
    int          n;
    logic [6:0]  len7;
    logic [63:0] pattern;
    logic [63:0] len_word;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_bit    = 1'b0;
    first_bit   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = REG_PATTERN_BITS;
    cfg_data    = '0;
    cur_pattern = '0;
    cur_len     = 0;
    sent        = 0;
    phases      = 0;
    no_gaps     = 1'b0;
    no_stall    = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Matching is disabled by the reset length of zero.
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);

    // One-bit pattern: every 1 is a match, with deltas between them.
    configure(64'h1, 64'd1, 1'b1);
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);

    // Self-overlapping 1-0-1: the overlapping match at 2 must be skipped,
    // and nothing matches before three bits have arrived.
    configure(64'h5, 64'd3, 1'b0);
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);
    // A restart mid-stream counts from zero again.
    push_bit(1'b1, 1'b1);
    push_bit(1'b0, 1'b0);
    push_bit(1'b1, 1'b0);

    // Length field of zero with all upper data bits set stays disabled.
    configure('1, 64'hFFFF_FFFF_FFFF_FF80, 1'b0);
    push_bit(1'b1, 1'b0);
    push_bit(1'b1, 1'b0);

    // Random phases: each picks a setting, then mixes whole patterns,
    // broken patterns and noise. The stream history carries across phases
    // unless a restart bit comes.
    goal = sent + RANDOM_BITS;
    k    = 0;
    while (sent < goal) begin
      pattern = {$urandom, $urandom};
      roll    = $urandom_range(0, 99);
      if (k == 0) begin
        pattern = '1;
        len7    = 7'd64;
      end else if (k == 1) begin
        pattern = '0;
        len7    = 7'($urandom_range(65, 127));
      end else if (roll < 8) begin
        len7 = 7'd0;
      end else if (roll < 16) begin
        len7 = 7'd1;
      end else if (roll < 24) begin
        len7 = 7'd64;
      end else if (roll < 32) begin
        len7 = 7'($urandom_range(65, 127));
      end else if (roll < 60) begin
        len7 = 7'($urandom_range(2, 8));
      end else begin
        len7 = 7'($urandom_range(9, 24));
      end
      if (k > 1 && $urandom_range(0, 9) == 0) begin
        pattern = $urandom_range(0, 1) ? '1 : '0;
      end
      len_word = {$urandom, $urandom};
      if ($urandom_range(0, 1)) begin
        len_word = '0;
      end
      len_word[6:0] = len7;
      configure(pattern, len_word, $urandom_range(0, 3) == 0);
      no_gaps  = ($urandom_range(0, 3) == 0);
      no_stall = ($urandom_range(0, 3) == 0);
      k++;

      if ($urandom_range(0, 1)) begin
        push_bit($urandom_range(0, 1), 1'b1);
      end
      phase_end = sent + $urandom_range(60, 130);
      while (sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (cur_len != 0 && roll < 70) begin
          repeat ($urandom_range(0, 3)) push_bit($urandom_range(0, 1), 1'b0);
          send_pattern(1'b0);
        end else if (cur_len != 0 && roll < 85) begin
          send_pattern(1'b1);
        end else begin
          repeat ($urandom_range(1, 10)) begin
            push_bit($urandom_range(0, 1), $urandom_range(0, 99) < 4);
          end
        end
      end
    end

    // Drain: wait for outstanding matches, then for the pipeline to empty.
    in_valid <= 1'b0;
    for (n = 0; n < END_WAIT_LIMIT && pending != 0; n++) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (pending != 0) begin
      $display("%0t: %0d predicted matches were never reported", $time, pending);
    end
    $display("Summary: %0d stream bits under %0d register settings", sent, phases);
    $display("Summary: %0d matches compared, %0d errors", matches_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
